// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms; define NO_ASSERTIONS to leave them out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMP(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// File: hw/rtl/mfbs_pkg.sv
// ----------------------------------------------------------------------------
// mfbs_pkg
// Types and constants shared by the message framer modules.
// ----------------------------------------------------------------------------
package mfbs_pkg;

   // Capacity of the payload buffer in bytes.
   localparam int unsigned MAX_PAYLOAD  = 4096;
   localparam int unsigned HEADER_BYTES = 24;

   localparam int unsigned CNT_W  = $clog2(MAX_PAYLOAD + 1);
   localparam int unsigned POS_W  = $clog2(MAX_PAYLOAD + HEADER_BYTES);
   localparam int unsigned ADDR_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

   localparam logic [CNT_W-1:0] COUNT_FULL   = CNT_W'(MAX_PAYLOAD);
   localparam logic [POS_W-1:0] POS_HEADER   = POS_W'(HEADER_BYTES);
   localparam logic [POS_W-1:0] POS_HDR_LAST = POS_W'(HEADER_BYTES - 1);

   // Queue between the front and back parts.
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam logic [QCNT_W-1:0] QUEUE_FULL = QCNT_W'(QUEUE_DEPTH);

   // Input kind codes.
   localparam logic [1:0] KIND_BEGIN   = 2'd0;
   localparam logic [1:0] KIND_PAYLOAD = 2'd1;
   localparam logic [1:0] KIND_TICK    = 2'd2;

   // Header word indexes (word address within the 24-byte header).
   localparam logic [2:0] HW_COMMAND = 3'd0;
   localparam logic [2:0] HW_FIRST   = 3'd1;
   localparam logic [2:0] HW_SECOND  = 3'd2;
   localparam logic [2:0] HW_LENGTH  = 3'd3;
   localparam logic [2:0] HW_SUM     = 3'd4;

   typedef enum logic [1:0] {
      OP_BEGIN,
      OP_PAYLOAD,
      OP_TICK
   } op_type;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_LOADING,
      PH_SENDING
   } phase_type;

   // One classified word waiting for the back part.  The arm bit is the
   // empty-payload flag on a begin word and the last-byte flag on a payload.
   typedef struct packed {
      op_type      op;
      logic [31:0] command;
      logic [31:0] first_arg;
      logic [31:0] second_arg;
      logic        arm;
      logic [7:0]  data;
   } item_type;

endpackage

// File: hw/rtl/mfbs_ram.sv
// ----------------------------------------------------------------------------
// mfbs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mfbs_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 4096
) (
   input  logic                                          clock,
   input  logic                                          wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  wr_addr,
   input  logic [WIDTH-1:0]                              wr_data,
   input  logic                                          rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  rd_addr,
   output logic [WIDTH-1:0]                              rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/mfbs_front.sv
// ----------------------------------------------------------------------------
// mfbs_front
// Accepts input words, classifies them and holds them in a short queue.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mfbs_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_kind,
   input  logic [31:0]        req_command,
   input  logic [31:0]        req_first_arg,
   input  logic [31:0]        req_second_arg,
   input  logic               req_empty_payload,
   input  logic [7:0]         req_payload_byte,
   input  logic               req_last_byte,
   output logic               q_valid,
   output mfbs_pkg::item_type q_item,
   input  logic               q_take
);

   mfbs_pkg::item_type                  slot_ff [mfbs_pkg::QUEUE_DEPTH];
   logic [mfbs_pkg::QPTR_W-1:0]         head_ff, head_in;
   logic [mfbs_pkg::QPTR_W-1:0]         tail_ff, tail_in;
   logic [mfbs_pkg::QCNT_W-1:0]         count_ff, count_in;
   mfbs_pkg::item_type                  item;
   logic                                keep;
   logic                                push;
   logic                                pop;

   // Classify the word; the unused kind code is accepted and dropped here.
   always_comb begin
      keep            = 1'b1;
      item.op         = mfbs_pkg::OP_BEGIN;
      item.command    = req_command;
      item.first_arg  = req_first_arg;
      item.second_arg = req_second_arg;
      item.data       = req_payload_byte;
      item.arm        = req_empty_payload;
      case (req_kind)
         mfbs_pkg::KIND_BEGIN: begin
            item.op  = mfbs_pkg::OP_BEGIN;
            item.arm = req_empty_payload;
         end
         mfbs_pkg::KIND_PAYLOAD: begin
            item.op  = mfbs_pkg::OP_PAYLOAD;
            item.arm = req_last_byte;
         end
         mfbs_pkg::KIND_TICK: begin
            item.op  = mfbs_pkg::OP_TICK;
            item.arm = 1'b0;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   assign busy    = (count_ff == mfbs_pkg::QUEUE_FULL);
   assign push    = start && !busy && keep;
   assign q_valid = (count_ff != '0);
   assign pop     = q_valid && q_take;
   assign q_item  = slot_ff[head_ff];

   always_comb begin
      head_in  = pop  ? head_ff + 1'b1 : head_ff;
      tail_in  = push ? tail_ff + 1'b1 : tail_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
      if (push) begin
         slot_ff[tail_ff] <= item;
      end
   end

   `ASSERT_IMP(a_queue_bound, clock, reset, 1'b1, count_ff <= mfbs_pkg::QUEUE_FULL)
   `ASSERT_NEXT(a_queue_grows, clock, reset, push && !pop, count_ff == $past(count_ff) + 1'b1)

endmodule

// File: hw/rtl/mfbs_back.sv
// ----------------------------------------------------------------------------
// mfbs_back
// Carries out queued words: builds the message state and emits frame bytes.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mfbs_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   input  mfbs_pkg::item_type q_item,
   output logic               q_take,
   output logic               rsp_valid,
   output logic [7:0]         rsp_out_byte,
   output logic               rsp_end_of_frame,
   output logic               rsp_truncated
);

   mfbs_pkg::phase_type              phase_ff, phase_in;
   logic [31:0]                      sum_ff, sum_in;
   logic [mfbs_pkg::CNT_W-1:0]       count_ff, count_in;
   logic [mfbs_pkg::POS_W-1:0]       pos_ff, pos_in;
   logic                             ovf_ff, ovf_in;
   logic [31:0]                      cmd_ff, cmd_in;
   logic [31:0]                      first_ff, first_in;
   logic [31:0]                      second_ff, second_in;

   // Output stage.
   logic                             s2_valid_ff, s2_valid_in;
   logic                             s2_from_ram_ff, s2_from_ram_in;
   logic [7:0]                       s2_hdr_ff, s2_hdr_in;
   logic                             s2_eof_ff, s2_eof_in;
   logic                             s2_trunc_ff, s2_trunc_in;

   logic                             take;
   logic                             is_last;
   logic                             in_payload;
   logic                             has_room;
   logic [31:0]                      hdr_word;
   logic [7:0]                       hdr_byte;
   logic [mfbs_pkg::POS_W-1:0]       offset;
   logic                             wr_en;
   logic                             rd_en;
   logic [7:0]                       rd_data;

   assign take    = q_valid;
   assign q_take  = take;

   assign is_last    = (pos_ff >= (mfbs_pkg::POS_W'(count_ff) + mfbs_pkg::POS_HDR_LAST));
   assign in_payload = (pos_ff >= mfbs_pkg::POS_HEADER);
   assign has_room   = (count_ff < mfbs_pkg::COUNT_FULL);
   assign offset     = pos_ff - mfbs_pkg::POS_HEADER;

   always_comb begin
      case (pos_ff[4:2])
         mfbs_pkg::HW_COMMAND: hdr_word = cmd_ff;
         mfbs_pkg::HW_FIRST:   hdr_word = first_ff;
         mfbs_pkg::HW_SECOND:  hdr_word = second_ff;
         mfbs_pkg::HW_LENGTH:  hdr_word = 32'(count_ff);
         mfbs_pkg::HW_SUM:     hdr_word = sum_ff;
         default:              hdr_word = ~cmd_ff;
      endcase
   end

   always_comb begin
      case (pos_ff[1:0])
         2'd0:    hdr_byte = hdr_word[7:0];
         2'd1:    hdr_byte = hdr_word[15:8];
         2'd2:    hdr_byte = hdr_word[23:16];
         default: hdr_byte = hdr_word[31:24];
      endcase
   end

   // Phase sequencing.
   always_comb begin
      phase_in = phase_ff;
      if (take) begin
         case (q_item.op)
            mfbs_pkg::OP_BEGIN: begin
               phase_in = q_item.arm ? mfbs_pkg::PH_SENDING : mfbs_pkg::PH_LOADING;
            end
            mfbs_pkg::OP_PAYLOAD: begin
               if (phase_ff == mfbs_pkg::PH_LOADING && q_item.arm) begin
                  phase_in = mfbs_pkg::PH_SENDING;
               end
            end
            mfbs_pkg::OP_TICK: begin
               if (phase_ff == mfbs_pkg::PH_SENDING && is_last) begin
                  phase_in = mfbs_pkg::PH_IDLE;
               end
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
      end
   end

   // Datapath updates and frame byte generation.
   always_comb begin
      sum_in         = sum_ff;
      count_in       = count_ff;
      pos_in         = pos_ff;
      ovf_in         = ovf_ff;
      cmd_in         = cmd_ff;
      first_in       = first_ff;
      second_in      = second_ff;
      wr_en          = 1'b0;
      rd_en          = 1'b0;
      s2_valid_in    = 1'b0;
      s2_from_ram_in = in_payload;
      s2_hdr_in      = hdr_byte;
      s2_eof_in      = is_last;
      s2_trunc_in    = ovf_ff;
      if (take) begin
         case (q_item.op)
            mfbs_pkg::OP_BEGIN: begin
               cmd_in    = q_item.command;
               first_in  = q_item.first_arg;
               second_in = q_item.second_arg;
               sum_in    = '0;
               count_in  = '0;
               ovf_in    = 1'b0;
               pos_in    = '0;
            end
            mfbs_pkg::OP_PAYLOAD: begin
               if (phase_ff == mfbs_pkg::PH_LOADING) begin
                  if (has_room) begin
                     wr_en    = 1'b1;
                     sum_in   = sum_ff + 32'(q_item.data);
                     count_in = count_ff + 1'b1;
                  end else begin
                     ovf_in = 1'b1;
                  end
                  if (q_item.arm) begin
                     pos_in = '0;
                  end
               end
            end
            mfbs_pkg::OP_TICK: begin
               if (phase_ff == mfbs_pkg::PH_SENDING) begin
                  s2_valid_in = 1'b1;
                  rd_en       = in_payload;
                  pos_in      = is_last ? '0 : pos_ff + 1'b1;
               end
            end
            default: begin
               s2_valid_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= mfbs_pkg::PH_IDLE;
         sum_ff      <= '0;
         count_ff    <= '0;
         pos_ff      <= '0;
         ovf_ff      <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         sum_ff      <= sum_in;
         count_ff    <= count_in;
         pos_ff      <= pos_in;
         ovf_ff      <= ovf_in;
         s2_valid_ff <= s2_valid_in;
      end
      cmd_ff         <= cmd_in;
      first_ff       <= first_in;
      second_ff      <= second_in;
      s2_from_ram_ff <= s2_from_ram_in;
      s2_hdr_ff      <= s2_hdr_in;
      s2_eof_ff      <= s2_eof_in;
      s2_trunc_ff    <= s2_trunc_in;
   end

   mfbs_ram #(
      .WIDTH (8),
      .DEPTH (mfbs_pkg::MAX_PAYLOAD)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[mfbs_pkg::ADDR_W-1:0]),
      .wr_data (q_item.data),
      .rd_en   (rd_en),
      .rd_addr (offset[mfbs_pkg::ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   assign rsp_valid        = s2_valid_ff;
   assign rsp_out_byte     = s2_from_ram_ff ? rd_data : s2_hdr_ff;
   assign rsp_end_of_frame = s2_eof_ff;
   assign rsp_truncated    = s2_trunc_ff;

   `ASSERT_IMP(a_rsp_while_sending, clock, reset, s2_valid_ff, $past(phase_ff) == mfbs_pkg::PH_SENDING)
   `ASSERT_IMP(a_count_bound, clock, reset, 1'b1, count_ff <= mfbs_pkg::COUNT_FULL)
   `ASSERT_NEXT(a_last_to_idle, clock, reset, s2_valid_in && is_last, phase_ff == mfbs_pkg::PH_IDLE)

endmodule

// File: hw/rtl/message_framer_with_byte_sum.sv
// ----------------------------------------------------------------------------
// message_framer_with_byte_sum
// Builds one framed message and streams it out a byte per output tick.
// ----------------------------------------------------------------------------
// Usage. A word is taken on a rising edge where start is high and busy is
// low; req_kind says what it is. A begin word latches the command and both
// arguments and opens a new message; payload words append a byte to the
// buffer, keeping a 32-bit wrapping byte sum and a count; the word flagged
// as last (or a begin with an empty payload) arms sending. Each output tick
// then emits one frame byte: a 24-byte little-endian header of command,
// first argument, second argument, length, byte sum and inverted command,
// followed by the stored payload. Payload beyond the buffer is dropped and
// every byte of that frame carries the truncated flag.
// Timing. A word passes a four-entry queue to the back part, which carries
// out one word per cycle, so the block sustains one word per cycle and busy
// never rises. A frame byte is marked by rsp_valid for exactly one cycle:
// its tick is first held in the queue, and the byte is then held in the
// output register. The payload buffer's registered read port lines up
// with that output register.
// Reset clears the queue and returns the block to idle with no message.
// Results cannot be held off by the receiver, so the back part never stalls.
// ----------------------------------------------------------------------------
module message_framer_with_byte_sum (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_kind,
   input  logic [31:0] req_command,
   input  logic [31:0] req_first_arg,
   input  logic [31:0] req_second_arg,
   input  logic        req_empty_payload,
   input  logic [7:0]  req_payload_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_end_of_frame,
   output logic        rsp_truncated
);

   // Classified words travelling from the front part to the back part.
   logic               q_valid;
   logic               q_take;
   mfbs_pkg::item_type q_item;

   // The front part registers and classifies incoming words.
   mfbs_front u_front (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_kind          (req_kind),
      .req_command       (req_command),
      .req_first_arg     (req_first_arg),
      .req_second_arg    (req_second_arg),
      .req_empty_payload (req_empty_payload),
      .req_payload_byte  (req_payload_byte),
      .req_last_byte     (req_last_byte),
      .q_valid           (q_valid),
      .q_item            (q_item),
      .q_take            (q_take)
   );

   // The back part owns the message state, the payload buffer and the
   // output register.
   mfbs_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_valid          (q_valid),
      .q_item           (q_item),
      .q_take           (q_take),
      .rsp_valid        (rsp_valid),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_end_of_frame (rsp_end_of_frame),
      .rsp_truncated    (rsp_truncated)
   );

endmodule
